// ----- rtl/tsc_pkg.sv -----
`default_nettype none
package tsc_pkg;

  // one vertex as it sits in the queue between front and back
  typedef struct packed {
    logic               start;
    logic signed [31:0] cz;
    logic signed [31:0] cy;
    logic signed [31:0] cx;
    logic signed [31:0] cw;
    logic [5:0]         vcode;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] offset_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] offset_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] offset_z;
    logic signed [31:0] guard_min;
    logic signed [31:0] guard_max;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_SCALE_X   = 3'd0,
    REG_OFFSET_X  = 3'd1,
    REG_SCALE_Y   = 3'd2,
    REG_OFFSET_Y  = 3'd3,
    REG_SCALE_Z   = 3'd4,
    REG_OFFSET_Z  = 3'd5,
    REG_GUARD_MIN = 3'd6,
    REG_GUARD_MAX = 3'd7
  } reg_idx_e;

  localparam int unsigned NumRegs = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_MAP,
    ST_CHECK,
    ST_AREA_MUL,
    ST_AREA_CMP,
    ST_EMIT
  } back_state_e;

  localparam logic [5:0] CodeAll = 6'h3F;
  localparam logic signed [31:0] Int32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Int32Min = 32'sh8000_0000;

endpackage
`default_nettype wire

// ----- rtl/tsc_front.sv -----
`default_nettype none
module tsc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            start_i,
  input  wire logic [127:0]    clip_i,
  output logic                 q_valid_o,
  input  wire logic            q_ready_i,
  output tsc_pkg::vertex_t     q_data_o
);

  tsc_pkg::vertex_t ent_q [2];
  tsc_pkg::vertex_t vin;
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;
  logic signed [32:0] w33, nw33, c33 [3];

  always_comb begin
    vin.start = start_i;
    vin.cx    = $signed(clip_i[31:0]);
    vin.cy    = $signed(clip_i[63:32]);
    vin.cz    = $signed(clip_i[95:64]);
    vin.cw    = $signed(clip_i[127:96]);
    w33       = 33'(vin.cw);
    nw33      = -w33;
    c33[0]    = 33'(vin.cx);
    c33[1]    = 33'(vin.cy);
    c33[2]    = 33'(vin.cz);
    // viewport test against -w and +w before the divide
    for (int a = 0; a < 3; a++) begin
      vin.vcode[2*a]   = c33[a] < nw33;
      vin.vcode[2*a+1] = c33[a] > w33;
    end
  end

  assign in_ready_o = cnt_q != 2'd2;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_data_o   = ent_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= vin;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tsc_div.sv -----
`default_nettype none
module tsc_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);

  localparam int unsigned NB = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NB + 1);

  logic [NB-1:0] num_q, quo_q;
  logic [31:0]   den_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q, run_q, done_q;
  logic [32:0]   trial;
  logic          take;
  logic [31:0]   num_mag, den_mag;
  logic          over_pos, over_neg;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);
  // one quotient bit a cycle, restoring
  assign trial   = {rem_q, num_q[NB-1]};
  assign take    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NB);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_mag, {FRAC_BITS{1'b0}}};
      den_q <= den_mag;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= num_i[31] ^ den_i[31];
    end else if (run_q) begin
      num_q <= {num_q[NB-2:0], 1'b0};
      rem_q <= take ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quo_q <= {quo_q[NB-2:0], take};
    end
  end

  assign over_pos = |quo_q[NB-1:31];
  assign over_neg = (|quo_q[NB-1:32]) || (quo_q[31] && (|quo_q[30:0]));

  always_comb begin
    if (!neg_q) begin
      quot_o = over_pos ? tsc_pkg::Int32Max : $signed(quo_q[31:0]);
    end else begin
      quot_o = over_neg ? tsc_pkg::Int32Min : $signed(32'(-quo_q[31:0]));
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- rtl/tsc_back.sv -----
`default_nettype none
module tsc_back #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned PRIM_INDEX_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tsc_pkg::cfg_t    cfg_i,
  input  wire logic             q_valid_i,
  output logic                  q_ready_o,
  input  wire tsc_pkg::vertex_t q_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [111:0]          out_data_o,
  output logic                  out_last_o
);

  localparam int unsigned SW  = 66;
  localparam int unsigned SH  = 2 * FRAC_BITS;
  localparam logic signed [SW-1:0] Rnd = SW'((66'sd1 <<< SH) - 66'sd1);

  tsc_pkg::back_state_e state_q, state_d;

  tsc_pkg::vertex_t   v_q, v_d;
  logic [1:0]         axis_q, axis_d, phase_q, phase_d, emit_q, emit_d;
  logic [5:0]         vand_q, vand_d, gor_q, gor_d;
  logic [PRIM_INDEX_BITS-1:0] count_q, count_d;
  logic signed [31:0] ndc_q, ndc_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] scr_q [3];
  logic signed [31:0] scr_d [3];
  logic signed [31:0] hx_q [2], hy_q [2], hz_q [2];
  logic signed [65:0] p1_q, p1_d, p2_q, p2_d;
  logic               hold_we;

  logic               div_start, div_done;
  logic signed [31:0] div_num, div_quot, scale_sel, off_sel, nxt_num;
  logic signed [SW-1:0] sum, rnd;
  logic signed [32:0] dx1, dy2, dx2, dy1;
  logic [1:0]         gbits;

  always_comb begin
    case (axis_q)
      2'd0:    div_num = v_q.cx;
      2'd1:    div_num = v_q.cy;
      default: div_num = v_q.cz;
    endcase
    case (axis_q)
      2'd0:    begin scale_sel = cfg_i.scale_x; off_sel = cfg_i.offset_x; end
      2'd1:    begin scale_sel = cfg_i.scale_y; off_sel = cfg_i.offset_y; end
      default: begin scale_sel = cfg_i.scale_z; off_sel = cfg_i.offset_z; end
    endcase
  end

  // the divider loads the coordinate of the axis about to be worked on
  always_comb begin
    case (axis_d)
      2'd0:    nxt_num = v_d.cx;
      2'd1:    nxt_num = v_d.cy;
      default: nxt_num = v_d.cz;
    endcase
  end

  tsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (nxt_num),
    .den_i  (v_d.cw),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // exact map then truncation toward zero
  assign sum = SW'(prod_q) + (SW'(off_sel) <<< FRAC_BITS);
  assign rnd = (sum + (sum[SW-1] ? Rnd : SW'(0))) >>> SH;

  assign gbits = {ndc_q > cfg_i.guard_max, ndc_q < cfg_i.guard_min};

  assign dx1 = 33'(hx_q[1]) - 33'(hx_q[0]);
  assign dy2 = 33'(scr_q[1]) - 33'(hy_q[0]);
  assign dx2 = 33'(scr_q[0]) - 33'(hx_q[0]);
  assign dy1 = 33'(hy_q[1]) - 33'(hy_q[0]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsc_pkg::ST_IDLE:     if (q_valid_i) state_d = tsc_pkg::ST_DIV;
      tsc_pkg::ST_DIV:      if (div_done) state_d = tsc_pkg::ST_MUL;
      tsc_pkg::ST_MUL:      state_d = tsc_pkg::ST_MAP;
      tsc_pkg::ST_MAP:      state_d = (axis_q == 2'd2) ? tsc_pkg::ST_CHECK : tsc_pkg::ST_DIV;
      tsc_pkg::ST_CHECK: begin
        if (phase_q != 2'd2 || vand_q != 6'd0 || gor_q != 6'd0) begin
          state_d = tsc_pkg::ST_IDLE;
        end else begin
          state_d = tsc_pkg::ST_AREA_MUL;
        end
      end
      tsc_pkg::ST_AREA_MUL: state_d = tsc_pkg::ST_AREA_CMP;
      tsc_pkg::ST_AREA_CMP: state_d = (p1_q >= p2_q) ? tsc_pkg::ST_IDLE : tsc_pkg::ST_EMIT;
      tsc_pkg::ST_EMIT:     if (out_ready_i && emit_q == 2'd2) state_d = tsc_pkg::ST_IDLE;
      default:              state_d = tsc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_ready_o = 1'b0;
    div_start = 1'b0;
    hold_we   = 1'b0;
    v_d       = v_q;
    axis_d    = axis_q;
    phase_d   = phase_q;
    emit_d    = emit_q;
    vand_d    = vand_q;
    gor_d     = gor_q;
    count_d   = count_q;
    ndc_d     = ndc_q;
    prod_d    = prod_q;
    scr_d     = scr_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    case (state_q)
      tsc_pkg::ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          v_d    = q_data_i;
          axis_d = 2'd0;
          if (q_data_i.start) begin
            phase_d = 2'd0;
            count_d = '0;
            vand_d  = q_data_i.vcode;
            gor_d   = 6'd0;
          end else begin
            vand_d  = vand_q & q_data_i.vcode;
          end
        end
      end
      tsc_pkg::ST_DIV: begin
        if (div_done) begin
          if (v_q.cw == 32'sd0) begin
            ndc_d = div_num[31] ? tsc_pkg::Int32Min : tsc_pkg::Int32Max;
          end else begin
            ndc_d = div_quot;
          end
        end
      end
      tsc_pkg::ST_MUL: begin
        prod_d = ndc_q * scale_sel;
        if (v_q.cw == 32'sd0) begin
          gor_d = tsc_pkg::CodeAll;
        end else begin
          gor_d = gor_q | (6'(gbits) << {axis_q, 1'b0});
        end
      end
      tsc_pkg::ST_MAP: begin
        if (rnd > SW'(tsc_pkg::Int32Max)) begin
          scr_d[axis_q] = tsc_pkg::Int32Max;
        end else if (rnd < SW'(tsc_pkg::Int32Min)) begin
          scr_d[axis_q] = tsc_pkg::Int32Min;
        end else begin
          scr_d[axis_q] = rnd[31:0];
        end
        if (axis_q != 2'd2) begin
          axis_d    = axis_q + 2'd1;
          div_start = 1'b1;
        end
      end
      tsc_pkg::ST_CHECK: begin
        if (phase_q != 2'd2) begin
          hold_we = 1'b1;
          phase_d = phase_q + 2'd1;
        end else begin
          phase_d = 2'd0;
          vand_d  = tsc_pkg::CodeAll;
          gor_d   = 6'd0;
        end
      end
      tsc_pkg::ST_AREA_MUL: begin
        p1_d = dx1 * dy2;
        p2_d = dx2 * dy1;
      end
      tsc_pkg::ST_AREA_CMP: begin
        emit_d = 2'd0;
      end
      tsc_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          emit_d = emit_q + 2'd1;
          if (emit_q == 2'd2) count_d = count_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == tsc_pkg::ST_IDLE && q_valid_i) div_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsc_pkg::ST_IDLE;
      axis_q  <= 2'd0;
      phase_q <= 2'd0;
      emit_q  <= 2'd0;
      vand_q  <= tsc_pkg::CodeAll;
      gor_q   <= 6'd0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      phase_q <= phase_d;
      emit_q  <= emit_d;
      vand_q  <= vand_d;
      gor_q   <= gor_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    ndc_q  <= ndc_d;
    prod_q <= prod_d;
    scr_q  <= scr_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    if (hold_we) begin
      hx_q[phase_q[0]] <= scr_q[0];
      hy_q[phase_q[0]] <= scr_q[1];
      hz_q[phase_q[0]] <= scr_q[2];
    end
  end

  // emitted order is vertex 0, vertex 2, vertex 1
  always_comb begin
    case (emit_q)
      2'd0:    out_data_o = {16'(count_q), hz_q[0], hy_q[0], hx_q[0]};
      2'd1:    out_data_o = {16'(count_q), scr_q[2], scr_q[1], scr_q[0]};
      default: out_data_o = {16'(count_q), hz_q[1], hy_q[1], hx_q[1]};
    endcase
  end

  assign out_valid_o = state_q == tsc_pkg::ST_EMIT;
  assign out_last_o  = emit_q == 2'd2;

endmodule
`default_nettype wire

// ----- rtl/triangle_setup_and_cull_unit.sv -----
// Triangle setup and cull.
// s_axis carries one clip-space vertex per transaction (Q16.16 x, y, z, w in
// tdata, start of batch in tuser). Vertices group in threes; a batch start
// restarts the grouping and the primitive index.
// m_axis carries three transactions per surviving triangle, vertices 0, 2, 1,
// with tlast on the third; culled triangles produce nothing.
// cfg_* writes the viewport scale/offset and guard-band registers; cfg_ready_o
// is always high. Write only while the block is idle.
// Each vertex passes through the back end one axis at a time, each axis using
// the bit-serial divider shared by the three axes; a surviving triangle adds
// an area test before its output transactions.
// A two-entry queue sits in front of the divider, so up to two vertices are
// taken while the back end is busy or the receiver stalls; the output is held
// stable until taken.
// Reset empties the queue, clears the batch state and loads the default
// registers (unit scales, zero offsets, guard band of plus and minus four).
`default_nettype none
module triangle_setup_and_cull_unit #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned PRIM_INDEX_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // clip_x, clip_y, clip_z, clip_w
  input  wire logic         s_axis_tuser,  // start_batch
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata,  // screen_x, screen_y, screen_z, prim_index
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [7:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  tsc_pkg::cfg_t    cfg_q;
  tsc_pkg::vertex_t q_data;
  logic             q_valid, q_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_x   <= 32'sd65536;
      cfg_q.offset_x  <= 32'sd0;
      cfg_q.scale_y   <= 32'sd65536;
      cfg_q.offset_y  <= 32'sd0;
      cfg_q.scale_z   <= 32'sd65536;
      cfg_q.offset_z  <= 32'sd0;
      cfg_q.guard_min <= -32'sd262144;
      cfg_q.guard_max <= 32'sd262144;
    end else if (cfg_valid_i && cfg_index_i < 8'(tsc_pkg::NumRegs)) begin
      case (tsc_pkg::reg_idx_e'(cfg_index_i[2:0]))
        tsc_pkg::REG_SCALE_X:   cfg_q.scale_x   <= cfg_data_i;
        tsc_pkg::REG_OFFSET_X:  cfg_q.offset_x  <= cfg_data_i;
        tsc_pkg::REG_SCALE_Y:   cfg_q.scale_y   <= cfg_data_i;
        tsc_pkg::REG_OFFSET_Y:  cfg_q.offset_y  <= cfg_data_i;
        tsc_pkg::REG_SCALE_Z:   cfg_q.scale_z   <= cfg_data_i;
        tsc_pkg::REG_OFFSET_Z:  cfg_q.offset_z  <= cfg_data_i;
        tsc_pkg::REG_GUARD_MIN: cfg_q.guard_min <= cfg_data_i;
        tsc_pkg::REG_GUARD_MAX: cfg_q.guard_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tsc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .start_i   (s_axis_tuser),
    .clip_i    (s_axis_tdata),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_data_o  (q_data)
  );

  tsc_back #(
    .FRAC_BITS      (FRAC_BITS),
    .PRIM_INDEX_BITS(PRIM_INDEX_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_data_i   (q_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/tsc_checker.sv -----
`default_nettype none
module tsc_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata,
  input wire logic         m_axis_tlast,
  input wire logic         cfg_ready_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output transaction changed");

  a_tri_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && $stable(m_axis_tdata[111:96]))
    else $error("triangle vertices not back to back with one index");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config channel not ready");

endmodule

bind triangle_setup_and_cull_unit tsc_checker u_tsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .cfg_ready_o  (cfg_ready_o)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      Frac     = 16;
  localparam longint  I32Max   = 64'sd2147483647;
  localparam longint  I32Min   = -64'sd2147483648;
  localparam longint  One      = 64'sd65536;
  localparam int      SettleCy = 1000;

  typedef struct {
    bit                 start;
    logic signed [31:0] x, y, z, w;
  } vertex_in_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [15:0]        idx;
    bit                 last;
  } screen_vtx_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // clip_x, clip_y, clip_z, clip_w
  logic         s_axis_tuser = 1'b0;  // start_batch
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;  // screen_x, screen_y, screen_z, prim_index
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  triangle_setup_and_cull_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint      vp_regs[8] = '{65536, 0, 65536, 0, 65536, 0, -262144, 262144};
  int          phase_ctr;
  longint      held_sx[2], held_sy[2], held_sz[2];
  logic [5:0]  view_and, guard_or;
  logic [15:0] prim_ctr;

  vertex_in_t  vertex_q[$];
  screen_vtx_t screen_q[$];
  vertex_in_t  cur_vtx;
  int          src_idle_pct, snk_idle_pct;
  int          errors, vtx_sent, vtx_rcvd, tri_kept, tri_seen;

  function automatic longint sat32(longint v);
    if (v > I32Max) return I32Max;
    if (v < I32Min) return I32Min;
    return v;
  endfunction

  function automatic longint ndc_of(longint c, longint w);
    if (w == 0) return (c < 0) ? I32Min : I32Max;
    return sat32((c * (64'sd1 <<< Frac)) / w);
  endfunction

  function automatic longint to_screen(longint n, longint s, longint o);
    return sat32((n * s + o * (64'sd1 <<< Frac)) / (64'sd1 <<< (2 * Frac)));
  endfunction

  function automatic logic [5:0] outcode(longint a, longint b, longint c, longint lo,
                                         longint hi);
    return {c > hi, c < lo, b > hi, b < lo, a > hi, a < lo};
  endfunction

  task automatic project_vertex(vertex_in_t v);
    longint cx, cy, cz, cw, nx, ny, nz, sx, sy, sz;
    logic [5:0] gcode;
    logic signed [127:0] d1x, d1y, d2x, d2y;
    bit cull;
    cx = longint'(v.x); cy = longint'(v.y); cz = longint'(v.z); cw = longint'(v.w);
    if (v.start) begin
      phase_ctr = 0;
      prim_ctr = '0;
      view_and = tsc_pkg::CodeAll;
      guard_or = '0;
    end
    view_and &= outcode(cx, cy, cz, -cw, cw);
    nx = ndc_of(cx, cw);
    ny = ndc_of(cy, cw);
    nz = ndc_of(cz, cw);
    gcode = (cw == 0) ? tsc_pkg::CodeAll
                      : outcode(nx, ny, nz, vp_regs[tsc_pkg::REG_GUARD_MIN],
                                vp_regs[tsc_pkg::REG_GUARD_MAX]);
    guard_or |= gcode;
    sx = to_screen(nx, vp_regs[tsc_pkg::REG_SCALE_X], vp_regs[tsc_pkg::REG_OFFSET_X]);
    sy = to_screen(ny, vp_regs[tsc_pkg::REG_SCALE_Y], vp_regs[tsc_pkg::REG_OFFSET_Y]);
    sz = to_screen(nz, vp_regs[tsc_pkg::REG_SCALE_Z], vp_regs[tsc_pkg::REG_OFFSET_Z]);
    if (phase_ctr < 2) begin
      held_sx[phase_ctr] = sx;
      held_sy[phase_ctr] = sy;
      held_sz[phase_ctr] = sz;
      phase_ctr++;
      return;
    end
    tri_seen++;
    cull = (view_and != 0) || (guard_or != 0);
    view_and = tsc_pkg::CodeAll;
    guard_or = '0;
    phase_ctr = 0;
    if (!cull) begin
      // doubled area in order 0,1,2; wide enough that nothing overflows
      d1x = held_sx[1] - held_sx[0];
      d1y = held_sy[1] - held_sy[0];
      d2x = sx - held_sx[0];
      d2y = sy - held_sy[0];
      cull = (d1x * d2y) >= (d2x * d1y);
    end
    if (cull) return;
    tri_kept++;
    screen_q.push_back('{32'(held_sx[0]), 32'(held_sy[0]), 32'(held_sz[0]), prim_ctr, 1'b0});
    screen_q.push_back('{32'(sx), 32'(sy), 32'(sz), prim_ctr, 1'b0});
    screen_q.push_back('{32'(held_sx[1]), 32'(held_sy[1]), 32'(held_sz[1]), prim_ctr, 1'b1});
    prim_ctr++;
  endtask

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        project_vertex(cur_vtx);
        vtx_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (vertex_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_vtx = vertex_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_vtx.w, cur_vtx.z, cur_vtx.y, cur_vtx.x};
          s_axis_tuser <= cur_vtx.start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side and compare
  always @(posedge clk_i or negedge rst_ni) begin
    screen_vtx_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        vtx_rcvd++;
        if (screen_q.size() == 0) begin
          $error("unexpected output transaction %h", m_axis_tdata);
          errors++;
        end else begin
          e = screen_q.pop_front();
          if (m_axis_tdata[31:0] !== e.x) begin
            $error("screen_x exp %0d got %0d", e.x, $signed(m_axis_tdata[31:0]));
            errors++;
          end
          if (m_axis_tdata[63:32] !== e.y) begin
            $error("screen_y exp %0d got %0d", e.y, $signed(m_axis_tdata[63:32]));
            errors++;
          end
          if (m_axis_tdata[95:64] !== e.z) begin
            $error("screen_z exp %0d got %0d", e.z, $signed(m_axis_tdata[95:64]));
            errors++;
          end
          if (m_axis_tdata[111:96] !== e.idx) begin
            $error("prim_index exp %0d got %0d", e.idx, m_axis_tdata[111:96]);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic write_reg(tsc_pkg::reg_idx_e r, logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 8'(r);
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    vp_regs[r] = longint'(signed'(v));
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (vertex_q.size() != 0 || s_axis_tvalid || screen_q.size() != 0);
    repeat (SettleCy) @(posedge clk_i);
  endtask

  function automatic void add_vtx(bit st, longint x, longint y, longint z, longint w);
    vertex_q.push_back('{st, 32'(x), 32'(y), 32'(z), 32'(w)});
  endfunction

  function automatic logic [31:0] wild();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed triangles, some with vertices pushed outside, plus noise
  function automatic void add_random(int n);
    longint w, span;
    int k;
    while (n > 0) begin
      if ($urandom_range(9) < 8) begin
        span = 0;
        for (k = 0; k < 3; k++) begin
          w = $urandom_range(1 << 22, 1 << 12);
          if ($urandom_range(7) == 0) w = -w;
          span = (w < 0 ? -w : w) * $urandom_range(5, 1) / 2;
          add_vtx(k == 0 && $urandom_range(7) == 0,
                  longint'($urandom_range(32'(2 * span))) - span,
                  longint'($urandom_range(32'(2 * span))) - span,
                  longint'($urandom_range(32'(2 * span))) - span, w);
        end
        n -= 3;
      end else begin
        vertex_q.push_back('{1'($urandom_range(1)), wild(), wild(), wild(), wild()});
        n--;
      end
    end
  endfunction

  initial begin
    errors = 0; vtx_sent = 0; vtx_rcvd = 0; tri_kept = 0; tri_seen = 0;
    phase_ctr = 0; view_and = tsc_pkg::CodeAll; guard_or = '0; prim_ctr = '0;
    src_idle_pct = 25;
    snk_idle_pct = 74;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset viewport
    add_vtx(1, 0, 0, 0, One);  add_vtx(0, 0, One, 0, One);  add_vtx(0, One, 0, 0, One);
    // opposite winding, then zero area
    add_vtx(0, 0, 0, 0, One);  add_vtx(0, One, 0, 0, One);  add_vtx(0, 0, One, 0, One);
    add_vtx(0, 0, 0, 0, One);  add_vtx(0, One, One, 0, One); add_vtx(0, 2 * One, 2 * One, 0, One);
    // all beyond +x, then one vertex with zero w
    add_vtx(0, 2 * One, 0, 0, One); add_vtx(0, 3 * One, One, 0, One);
    add_vtx(0, 2 * One, -One, 0, One);
    add_vtx(0, 0, 0, 0, One);  add_vtx(0, 0, One, 0, 0);    add_vtx(0, One, 0, 0, One);
    // one vertex outside the viewport and the guard band
    add_vtx(0, 0, 0, 0, One);  add_vtx(0, 0, One, 0, One);  add_vtx(0, 5 * One, 0, 0, One);
    // restart inside a triangle, then extremes and negative w
    add_vtx(0, One, One, 0, One); add_vtx(1, 0, 0, One, One);
    add_vtx(0, 0, One, -One, One); add_vtx(0, One, 0, One, One);
    add_vtx(0, I32Min, I32Max, I32Min, I32Max);
    add_vtx(0, I32Max, I32Min, I32Max, I32Min);
    add_vtx(0, -One, -One, -One, -One);
    drain();

    write_reg(tsc_pkg::REG_SCALE_X, 32'(320 * One));
    write_reg(tsc_pkg::REG_OFFSET_X, 32'(320 * One));
    write_reg(tsc_pkg::REG_SCALE_Y, 32'(-240 * One));
    write_reg(tsc_pkg::REG_OFFSET_Y, 32'(240 * One));
    write_reg(tsc_pkg::REG_SCALE_Z, 32'(1000 * One));
    write_reg(tsc_pkg::REG_OFFSET_Z, 32'(7 * One + 12345));
    write_reg(tsc_pkg::REG_GUARD_MIN, 32'(-2 * One));
    write_reg(tsc_pkg::REG_GUARD_MAX, 32'(2 * One));
    add_random(100);
    drain();

    src_idle_pct = 74;
    snk_idle_pct = 25;
    write_reg(tsc_pkg::REG_SCALE_X, 32'h7FFF_FFFF);
    write_reg(tsc_pkg::REG_OFFSET_X, 32'h8000_0000);
    write_reg(tsc_pkg::REG_SCALE_Y, 32'h8000_0000);
    write_reg(tsc_pkg::REG_OFFSET_Y, 32'h7FFF_FFFF);
    write_reg(tsc_pkg::REG_SCALE_Z, 32'h8000_0000);
    write_reg(tsc_pkg::REG_OFFSET_Z, 32'h7FFF_FFFF);
    write_reg(tsc_pkg::REG_GUARD_MIN, 32'h8000_0000);
    write_reg(tsc_pkg::REG_GUARD_MAX, 32'h7FFF_FFFF);
    add_random(100);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(tsc_pkg::REG_SCALE_X, 32'(1 << 14));
    write_reg(tsc_pkg::REG_OFFSET_X, 32'(-5 * One));
    write_reg(tsc_pkg::REG_SCALE_Y, 32'(3 << 20));
    write_reg(tsc_pkg::REG_OFFSET_Y, 32'd0);
    write_reg(tsc_pkg::REG_SCALE_Z, 32'(One));
    write_reg(tsc_pkg::REG_OFFSET_Z, 32'(-One / 2));
    write_reg(tsc_pkg::REG_GUARD_MIN, 32'(-One / 2 - 1));
    write_reg(tsc_pkg::REG_GUARD_MAX, 32'(One + One / 2));
    add_random(100);
    drain();

    $display("covered %0d vertices, %0d triangles, %0d kept, %0d output transactions",
             vtx_sent, tri_seen, tri_kept, vtx_rcvd);
    $display("across reset, mid-range and extreme viewport and guard-band settings");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
